/* rtl/edrq_pkg.sv */
// ----------------------------------------------------------------------------
// Elevator disk request queue package
// Shared sizes, codes and the packed result record.
// ----------------------------------------------------------------------------
package edrq_pkg;

  localparam int SLOTS  = 32;
  localparam int SLOT_W = 5;
  localparam int LINK_W = 6;
  localparam int KEY_W  = 29;
  localparam int INFO_W = 15;

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(SLOTS);
  localparam logic [1:0]        SECTORS   = 2'd2;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_OK  = 2'd1;
  localparam logic [1:0] OP_ERR = 2'd2;
  localparam logic [1:0] OP_NOP = 2'd3;

  localparam logic [2:0] ST_QUEUED = 3'd0;
  localparam logic [2:0] ST_FULL   = 3'd1;
  localparam logic [2:0] ST_SECTOR = 3'd2;
  localparam logic [2:0] ST_DONE   = 3'd3;
  localparam logic [2:0] ST_FAILED = 3'd4;
  localparam logic [2:0] ST_RETRY  = 3'd5;
  localparam logic [2:0] ST_NONE   = 3'd6;

  typedef struct packed {
    logic        half;
    logic [7:0]  done_tag;
    logic        iwrite;
    logic [1:0]  icount;
    logic [7:0]  isector;
    logic [3:0]  ihead;
    logic [15:0] icyl;
    logic        idrive;
    logic        ivalid;
    logic [4:0]  slot;
  } res_t;

endpackage

/* rtl/edrq_ram.sv */
// ----------------------------------------------------------------------------
// Elevator disk request queue RAM
// Simple dual-port memory with one write port and a registered read port.
// ----------------------------------------------------------------------------
module edrq_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic         clk,
  input  logic         we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/elevator_disk_request_queue.sv */
// Throughput: one request at a time; the next is taken once the result is delivered.
// The cost of an add is set by the linked-list walk, one entry at a time on one read port.
// Reset clears all slot-used bits, the list head and the busy flag at once;
// max_retries returns to 5.
// ----------------------------------------------------------------------------
// Elevator disk request queue
// Slot pool with an elevator-ordered linked list held in synchronous RAMs.
// ----------------------------------------------------------------------------
module elevator_disk_request_queue (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // drive, cylinder, head, sector, is_write, tag, zero fill
  input  logic [1:0]  s_tuser,  // op
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,  // slot, issue_valid, issue_drive, issue_cylinder,
                                // issue_head, issue_sector, issue_count, issue_write,
                                // done_tag, buffer_half, zero fill
  output logic [2:0]  m_tuser,  // status
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD, S_HEAD_RD, S_HEAD_CHK, S_WALK_RD, S_WALK_NX, S_WALK_CMP,
    S_LINK_S, S_LINK_T, S_FIN, S_ISSUE_RD, S_ISSUE_OUT, S_EV, S_EV_EXE, S_OUT
  } state_t;

  state_t state;
  logic [3:0] max_retries;
  logic [edrq_pkg::SLOTS-1:0] slot_used;
  logic [edrq_pkg::LINK_W-1:0] head;
  logic busy;
  logic [1:0] op;
  logic [edrq_pkg::KEY_W-1:0] ks;
  logic wr_in;
  logic [7:0] tag_in;
  logic [edrq_pkg::SLOT_W-1:0] sreg;
  logic [edrq_pkg::SLOT_W-1:0] t;
  logic [edrq_pkg::LINK_W-1:0] nx;
  logic [edrq_pkg::KEY_W-1:0] kt;
  logic [edrq_pkg::LINK_W-1:0] guard;
  logic half_lock;
  logic [2:0] st;
  edrq_pkg::res_t res;

  logic [edrq_pkg::KEY_W-1:0] key_q;
  logic [edrq_pkg::INFO_W-1:0] info_q;
  logic [edrq_pkg::LINK_W-1:0] link_q;
  logic [edrq_pkg::SLOT_W-1:0] raddr;
  logic key_we, info_we, link_we;
  logic [edrq_pkg::SLOT_W-1:0] info_wa, link_wa;
  logic [edrq_pkg::INFO_W-1:0] info_wd;
  logic [edrq_pkg::LINK_W-1:0] link_wd;
  logic [edrq_pkg::SLOT_W-1:0] free_s;
  logic full;
  logic [1:0] cnt, cnt1;
  logic [3:0] err, err1, errinc;
  logic ev_wr, brk;

  always_comb begin
    free_s = '0;
    full = 1'b1;
    for (int i = edrq_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!slot_used[i]) begin
        free_s = edrq_pkg::SLOT_W'(i);
        full = 1'b0;
      end
    end
  end

  assign cnt    = info_q[10:9];
  assign ev_wr  = info_q[8];
  assign err    = info_q[14:11];
  assign cnt1   = (cnt != 2'd0) ? cnt - 2'd1 : 2'd0;
  assign err1   = ev_wr ? err : 4'd0;
  assign errinc = (err != 4'd15) ? err + 4'd1 : 4'd15;
  assign brk    = ((kt < ks) || !(kt < key_q)) && (ks < key_q);

  always_comb begin
    raddr = head[edrq_pkg::SLOT_W-1:0];
    key_we = 1'b0;
    info_we = 1'b0;
    link_we = 1'b0;
    info_wa = head[edrq_pkg::SLOT_W-1:0];
    link_wa = sreg;
    info_wd = {4'd0, edrq_pkg::SECTORS, wr_in, tag_in};
    link_wd = edrq_pkg::NULL_LINK;
    case (state)
      S_ADD: begin
        key_we = !full;
        info_we = !full;
        link_we = !full;
        info_wa = free_s;
        link_wa = free_s;
      end
      S_HEAD_CHK: begin
        link_we = (link_q == edrq_pkg::NULL_LINK);
        link_wa = head[edrq_pkg::SLOT_W-1:0];
        link_wd = {1'b0, sreg};
      end
      S_WALK_RD: raddr = t;
      S_WALK_NX: raddr = link_q[edrq_pkg::SLOT_W-1:0];
      S_LINK_S: begin
        link_we = 1'b1;
        link_wd = nx;
      end
      S_LINK_T: begin
        link_we = 1'b1;
        link_wa = t;
        link_wd = {1'b0, sreg};
      end
      S_EV_EXE: begin
        if (op == edrq_pkg::OP_OK) begin
          info_we = 1'b1;
          info_wd = {err1, cnt1, info_q[8:0]};
        end else if (err < max_retries) begin
          info_we = 1'b1;
          info_wd = {errinc, info_q[10:0]};
        end
      end
      default: ;
    endcase
  end

  edrq_ram #(.W(edrq_pkg::KEY_W), .DEPTH(edrq_pkg::SLOTS), .AW(edrq_pkg::SLOT_W)) u_key (
    .clk(clk), .we(key_we), .waddr(free_s), .wdata(ks), .raddr(raddr), .rdata(key_q)
  );

  edrq_ram #(.W(edrq_pkg::INFO_W), .DEPTH(edrq_pkg::SLOTS), .AW(edrq_pkg::SLOT_W)) u_info (
    .clk(clk), .we(info_we), .waddr(info_wa), .wdata(info_wd), .raddr(raddr),
    .rdata(info_q)
  );

  edrq_ram #(.W(edrq_pkg::LINK_W), .DEPTH(edrq_pkg::SLOTS), .AW(edrq_pkg::SLOT_W)) u_link (
    .clk(clk), .we(link_we), .waddr(link_wa), .wdata(link_wd), .raddr(raddr),
    .rdata(link_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      max_retries <= 4'd5;
      slot_used <= '0;
      head <= edrq_pkg::NULL_LINK;
      busy <= 1'b0;
    end else begin
      if (psel && penable && pwrite && !paddr) begin
        max_retries <= pwdata[3:0];
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op <= s_tuser;
            ks <= {s_tdata[0], s_tdata[16:1], s_tdata[20:17], s_tdata[28:21]};
            wr_in <= s_tdata[29];
            tag_in <= s_tdata[37:30];
            res <= '0;
            st <= edrq_pkg::ST_NONE;
            half_lock <= 1'b0;
            guard <= '0;
            state <= (s_tuser == edrq_pkg::OP_ADD) ? S_ADD : S_EV;
          end
        end
        S_ADD: begin
          if (full) begin
            st <= edrq_pkg::ST_FULL;
            state <= S_OUT;
          end else begin
            slot_used[free_s] <= 1'b1;
            sreg <= free_s;
            if (head == edrq_pkg::NULL_LINK) begin
              head <= {1'b0, free_s};
              state <= S_FIN;
            end else begin
              state <= S_HEAD_RD;
            end
          end
        end
        S_HEAD_RD: state <= S_HEAD_CHK;
        S_HEAD_CHK: begin
          t <= link_q[edrq_pkg::SLOT_W-1:0];
          state <= (link_q == edrq_pkg::NULL_LINK) ? S_FIN : S_WALK_RD;
        end
        S_WALK_RD: state <= S_WALK_NX;
        S_WALK_NX: begin
          kt <= key_q;
          nx <= link_q;
          if (link_q == edrq_pkg::NULL_LINK || guard == edrq_pkg::LINK_W'(edrq_pkg::SLOTS)) begin
            state <= S_LINK_S;
          end else begin
            state <= S_WALK_CMP;
          end
        end
        S_WALK_CMP: begin
          if (brk) begin
            state <= S_LINK_S;
          end else begin
            t <= nx[edrq_pkg::SLOT_W-1:0];
            guard <= guard + 1'b1;
            state <= S_WALK_RD;
          end
        end
        S_LINK_S: state <= S_LINK_T;
        S_LINK_T: state <= S_FIN;
        S_FIN: begin
          st <= edrq_pkg::ST_QUEUED;
          res.slot <= sreg;
          state <= busy ? S_OUT : S_ISSUE_RD;
        end
        S_ISSUE_RD: begin
          if (head == edrq_pkg::NULL_LINK) begin
            busy <= 1'b0;
            state <= S_OUT;
          end else begin
            state <= S_ISSUE_OUT;
          end
        end
        S_ISSUE_OUT: begin
          busy <= 1'b1;
          res.ivalid <= 1'b1;
          res.idrive <= key_q[28];
          res.icyl <= key_q[27:12];
          res.ihead <= key_q[11:8];
          res.isector <= key_q[7:0];
          res.icount <= info_q[10:9];
          res.iwrite <= info_q[8];
          if (!half_lock) begin
            res.half <= info_q[8] & info_q[9];
          end
          state <= S_OUT;
        end
        S_EV: begin
          if (op == edrq_pkg::OP_NOP || head == edrq_pkg::NULL_LINK) begin
            state <= S_OUT;
          end else begin
            state <= S_EV_EXE;
          end
        end
        S_EV_EXE: begin
          res.slot <= head[edrq_pkg::SLOT_W-1:0];
          if (op == edrq_pkg::OP_OK) begin
            if (cnt1 != 2'd0) begin
              st <= edrq_pkg::ST_SECTOR;
              res.half <= ev_wr ? cnt1[0] : cnt[0];
              state <= S_OUT;
            end else begin
              st <= edrq_pkg::ST_DONE;
              res.done_tag <= info_q[7:0];
              slot_used[head[edrq_pkg::SLOT_W-1:0]] <= 1'b0;
              head <= link_q;
              if (!ev_wr) begin
                half_lock <= 1'b1;
                res.half <= cnt[0];
              end
              state <= S_ISSUE_RD;
            end
          end else if (err >= max_retries) begin
            st <= edrq_pkg::ST_FAILED;
            res.done_tag <= info_q[7:0];
            slot_used[head[edrq_pkg::SLOT_W-1:0]] <= 1'b0;
            head <= link_q;
            state <= S_ISSUE_RD;
          end else begin
            st <= edrq_pkg::ST_RETRY;
            busy <= 1'b1;
            res.ivalid <= 1'b1;
            res.idrive <= key_q[28];
            res.icyl <= key_q[27:12];
            res.ihead <= key_q[11:8];
            res.isector <= key_q[7:0];
            res.icount <= cnt;
            res.iwrite <= ev_wr;
            res.half <= ev_wr & cnt[0];
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tuser  = st;
  assign m_tdata  = {1'b0, res};
  assign prdata   = {28'd0, max_retries};
  assign pready   = 1'b1;

endmodule
